/* rtl/cisub_pkg.sv */
// ----------------------------------------------------------------------------
// cisub_pkg
// Shared types and helpers for the case-insensitive substring search.
// ----------------------------------------------------------------------------
package cisub_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_TEXT  = 2'd2,
        MODE_END   = 2'd3
    } mode_t;

    typedef struct packed {
        logic       text_en;
        logic       text_clr;
        logic       key_clr;
        logic       key_any;
        logic [7:0] data;
    } cisub_bcast_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

endpackage

/* rtl/cisub_cell.sv */
// ----------------------------------------------------------------------------
// cisub_cell
// One key position: holds a folded key byte and the partial match flag that
// moves one cell along the chain with every text byte.
// ----------------------------------------------------------------------------
module cisub_cell
    import cisub_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cisub_bcast_t bcast,
    input  logic         key_wr,
    input  logic         prev_match,
    output logic         match,
    output logic         hit
);

    logic [7:0] key_reg;
    logic       match_reg;
    logic       match_next;
    logic       last_reg;
    logic       last_next;

    assign match_next = prev_match && (key_reg == bcast.data);

    always_comb begin
        last_next = last_reg;
        if (bcast.key_clr) begin
            last_next = 1'b0;
        end else if (key_wr) begin
            last_next = 1'b1;
        end else if (bcast.key_any) begin
            last_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_reg <= bcast.data;
        end
        if (!aresetn) begin
            match_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            last_reg <= last_next;
            if (bcast.text_clr) begin
                match_reg <= 1'b0;
            end else if (bcast.text_en) begin
                match_reg <= match_next;
            end
        end
    end

    assign match = match_reg;
    assign hit   = bcast.text_en && last_reg && match_next;

endmodule

/* rtl/case_insensitive_substring_search.sv */
// Output: the m_ side registers a result in the cycle after its end-of-text
// request is accepted; key and text requests give no result.
// Throughput: one request per cycle unless a held result stalls s_ready,
// set by the key cell chain comparing every text byte to all key positions.
// Reset: synchronous, clears key length, overflow flag, text count and all
// match flags; stored key bytes stay undefined until written.
// ----------------------------------------------------------------------------
// case_insensitive_substring_search
// Streams a key and then a text and reports whether the key occurs in the
// text, ignoring ASCII letter case.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search
    import cisub_pkg::*;
#(
    parameter int KEY_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_found,
    output logic       m_key_too_long
);

    localparam int KL_W  = $clog2(KEY_MAX + 1);
    localparam int CNT_W = $clog2(KEY_MAX + 2);

    logic [KL_W-1:0]  kl_reg,  kl_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             seen_reg, seen_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic             m_ktl_reg,   m_ktl_next;

    logic         accept;
    mode_t        mode;
    logic         key_room;
    cisub_bcast_t bcast;
    logic [KEY_MAX-1:0] key_wr;
    logic [KEY_MAX:0]   chain;
    logic [KEY_MAX-1:0] hits;
    logic         hit;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign mode     = mode_t'(s_mode);
    assign key_room = (kl_reg != KL_W'(KEY_MAX));

    always_comb begin
        bcast.data     = fold_byte(s_byte_in);
        bcast.text_en  = accept && (mode == MODE_TEXT);
        bcast.text_clr = accept && (mode != MODE_TEXT);
        bcast.key_clr  = accept && (mode == MODE_CLEAR);
        bcast.key_any  = accept && (mode == MODE_KEY) && key_room;
    end

    assign chain[0] = 1'b1;

    for (genvar j = 0; j < KEY_MAX; j++) begin : g_cell
        assign key_wr[j] = bcast.key_any && (kl_reg == KL_W'(j));
        cisub_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .bcast      (bcast),
            .key_wr     (key_wr[j]),
            .prev_match (chain[j]),
            .match      (chain[j+1]),
            .hit        (hits[j])
        );
    end

    assign hit = (|hits) || (bcast.text_en && (kl_reg == '0));

    always_comb begin
        kl_next      = kl_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_found_next = m_found_reg;
        m_ktl_next   = m_ktl_reg;
        if (accept) begin
            unique case (mode)
                MODE_CLEAR: begin
                    kl_next   = '0;
                    ovf_next  = 1'b0;
                    cnt_next  = '0;
                    seen_next = 1'b0;
                end
                MODE_KEY: begin
                    cnt_next  = '0;
                    seen_next = 1'b0;
                    if (key_room) begin
                        kl_next = kl_reg + KL_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                MODE_TEXT: begin
                    if (cnt_reg != CNT_W'(KEY_MAX + 1)) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (hit) begin
                        seen_next = 1'b1;
                    end
                end
                MODE_END: begin
                    m_valid_next = 1'b1;
                    m_found_next = seen_reg && (cnt_reg > CNT_W'(kl_reg));
                    m_ktl_next   = ovf_reg;
                    cnt_next     = '0;
                    seen_next    = 1'b0;
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_ready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_ktl_reg   <= m_ktl_next;
        if (!aresetn) begin
            kl_reg      <= '0;
            ovf_reg     <= 1'b0;
            cnt_reg     <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            kl_reg      <= kl_next;
            ovf_reg     <= ovf_next;
            cnt_reg     <= cnt_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_key_too_long = m_ktl_reg;

endmodule
